// ----- rtl/tc8_pkg.sv -----
// ----------------------------------------------------------------------------
// tc8_pkg
// Shared types, codes and the prescaler tap table for the 8-bit timer/counter.
// ----------------------------------------------------------------------------
package tc8_pkg;

  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_WR_COUNT   = 3'd1,
    KIND_RD_COUNT   = 3'd2,
    KIND_WR_COMPARE = 3'd3,
    KIND_FORCE      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    WAVE_NORMAL = 2'd0,
    WAVE_CTC    = 2'd1,
    WAVE_PWM    = 2'd2
  } wave_t;

  typedef enum logic [1:0] {
    OUT_OFF    = 2'd0,
    OUT_TOGGLE = 2'd1,
    OUT_CLEAR  = 2'd2,
    OUT_SET    = 2'd3
  } out_mode_t;

  typedef enum logic [2:0] {
    REG_WAVE_MODE   = 3'd0,
    REG_OUTPUT_MODE = 3'd1,
    REG_CLOCK_SEL   = 3'd2,
    REG_OVF_IRQ_EN  = 3'd3,
    REG_CMP_IRQ_EN  = 3'd4
  } reg_index_t;

  localparam int PRESCALE_BITS = 10;
  localparam int CFG_DATA_BITS = 3;

  typedef struct packed {
    logic [1:0] wave_mode;
    logic [1:0] output_mode;
    logic [2:0] clock_select;
  } tc_cfg_t;

  typedef struct packed {
    logic [7:0] count;
    logic       pin;
    logic       ovf;
    logic       cmp;
  } tc_res_t;

  // low prescaler bits that must all be ones for a timer clock
  function automatic logic [PRESCALE_BITS-1:0] div_mask(input logic [2:0] sel);
    logic [PRESCALE_BITS-1:0] m;
    case (sel)
      3'd2:    m = 10'd7;
      3'd3:    m = 10'd63;
      3'd4:    m = 10'd255;
      3'd5:    m = 10'd1023;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/tc8_core.sv -----
// ----------------------------------------------------------------------------
// tc8_core
// Timer state (counter, prescaler, compare registers, pin) and its step logic.
// ----------------------------------------------------------------------------
module tc8_core #(
  parameter int COUNTER_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [2:0]       kind,
  input  logic [7:0]       value,
  input  tc8_pkg::tc_cfg_t cfg,
  input  logic             sync_compare,
  output tc8_pkg::tc_res_t res
);
  import tc8_pkg::*;

  logic [COUNTER_BITS-1:0]  counter, counter_next;
  logic [PRESCALE_BITS-1:0] prescale_count, prescale_count_next;
  logic [7:0]               compare_active, compare_active_next;
  logic [7:0]               compare_buffer, compare_buffer_next;
  logic                     pin_level, pin_level_next;
  logic                     match_blocked, match_blocked_next;

  logic                     pwm, ctc, running, tclk, match, ovf, cmp;
  logic [PRESCALE_BITS-1:0] mask;

  function automatic logic match_pin(input logic is_pwm, input logic [1:0] mode,
                                     input logic pin);
    logic p;
    p = pin;
    case (mode)
      OUT_TOGGLE: p = is_pwm ? pin : ~pin;
      OUT_CLEAR:  p = 1'b0;
      OUT_SET:    p = 1'b1;
      default:    p = pin;
    endcase
    return p;
  endfunction

  assign pwm     = (cfg.wave_mode == WAVE_PWM);
  assign ctc     = (cfg.wave_mode == WAVE_CTC);
  assign running = (cfg.clock_select >= 3'd1) && (cfg.clock_select <= 3'd5);
  assign mask    = div_mask(cfg.clock_select);
  assign tclk    = running && ((prescale_count & mask) == mask);
  assign match   = (counter == COUNTER_BITS'(compare_active)) && !match_blocked;

  always_comb begin
    counter_next        = counter;
    prescale_count_next = prescale_count;
    compare_active_next = compare_active;
    compare_buffer_next = compare_buffer;
    pin_level_next      = pin_level;
    match_blocked_next  = match_blocked;
    ovf                 = 1'b0;
    cmp                 = 1'b0;
    if (sync_compare) begin
      compare_active_next = compare_buffer;
    end
    if (step) begin
      case (kind)
        KIND_TICK: begin
          prescale_count_next = prescale_count + 1'b1;
          if (tclk) begin
            match_blocked_next = 1'b0;
            if (match) begin
              cmp            = 1'b1;
              pin_level_next = match_pin(pwm, cfg.output_mode, pin_level);
            end
            if (ctc && match) begin
              counter_next = '0;
            end else if (&counter) begin
              counter_next = '0;
              ovf          = 1'b1;
              if (pwm) begin
                // bottom action lands after the match action
                if (cfg.output_mode == OUT_CLEAR) pin_level_next = 1'b1;
                else if (cfg.output_mode == OUT_SET) pin_level_next = 1'b0;
                compare_active_next = compare_buffer;
              end
            end else begin
              counter_next = counter + 1'b1;
            end
          end
        end
        KIND_WR_COUNT: begin
          counter_next       = COUNTER_BITS'(value);
          match_blocked_next = 1'b1;
        end
        KIND_WR_COMPARE: begin
          compare_buffer_next = value;
          if (!pwm) compare_active_next = value;
        end
        KIND_FORCE: begin
          if (!pwm) pin_level_next = match_pin(1'b0, cfg.output_mode, pin_level);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter        <= '0;
      prescale_count <= '0;
      compare_active <= '0;
      compare_buffer <= '0;
      pin_level      <= 1'b0;
      match_blocked  <= 1'b0;
    end else begin
      counter        <= counter_next;
      prescale_count <= prescale_count_next;
      compare_active <= compare_active_next;
      compare_buffer <= compare_buffer_next;
      pin_level      <= pin_level_next;
      match_blocked  <= match_blocked_next;
    end
  end

  assign res.count = counter_next[7:0];
  assign res.pin   = pin_level_next;
  assign res.ovf   = ovf;
  assign res.cmp   = cmp;

endmodule

// ----- rtl/timer_counter_8bit_pwm.sv -----
// ----------------------------------------------------------------------------
// timer_counter_8bit_pwm
// 8-bit timer/counter: prescaler, normal / CTC / fast PWM, compare pin, irqs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------
//  in      | to block  | in_valid/in_stall  | kind, value
//  out     | from block| out_valid/out_stall| count, compare_pin, events, irqs
//  config  | to block  | wr_en              | wr_index, wr_data
//
//  One word per cycle unless held by out_stall; input, then result register.
//  The word is applied to the timer state as it moves from the input register
//  to the result register. in_stall rises only when both registers hold words
//  and out_stall is high. Reset (rst, synchronous) clears the timer, the
//  config registers and both valid flags.
// ----------------------------------------------------------------------------
module timer_counter_8bit_pwm #(
  parameter int COUNTER_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] count,
  output logic       compare_pin,
  output logic       overflow_event,
  output logic       compare_event,
  output logic       overflow_irq,
  output logic       compare_irq,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [tc8_pkg::CFG_DATA_BITS-1:0] wr_data
);
  import tc8_pkg::*;

  tc_cfg_t    cfg;
  logic       ovf_irq_en, cmp_irq_en;
  logic       sync_compare;

  logic       item_valid;
  logic [2:0] item_kind;
  logic [7:0] item_value;
  logic       advance, step;
  tc_res_t    res;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg        <= '0;
      ovf_irq_en <= 1'b0;
      cmp_irq_en <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_WAVE_MODE:   cfg.wave_mode    <= wr_data[1:0];
        REG_OUTPUT_MODE: cfg.output_mode  <= wr_data[1:0];
        REG_CLOCK_SEL:   cfg.clock_select <= wr_data;
        REG_OVF_IRQ_EN:  ovf_irq_en       <= wr_data[0];
        REG_CMP_IRQ_EN:  cmp_irq_en       <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  // leaving PWM (or rewriting a non-PWM mode) pulls the buffered compare in
  assign sync_compare = wr_en && (wr_index == REG_WAVE_MODE) && (wr_data[1:0] != WAVE_PWM);

  assign advance  = !out_valid || !out_stall;
  assign step     = item_valid && advance;
  assign in_stall = item_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_kind  <= kind;
      item_value <= value;
    end
  end

  tc8_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .kind         (item_kind),
    .value        (item_value),
    .cfg          (cfg),
    .sync_compare (sync_compare),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      count          <= res.count;
      compare_pin    <= res.pin;
      overflow_event <= res.ovf;
      compare_event  <= res.cmp;
      overflow_irq   <= res.ovf & ovf_irq_en;
      compare_irq    <= res.cmp & cmp_irq_en;
    end
  end

  a_ovf_irq_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow_irq) |-> overflow_event)
    else $error("overflow irq without overflow event");

  a_cmp_irq_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && compare_irq) |-> compare_event)
    else $error("compare irq without compare event");

  a_ovf_wraps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow_event) |-> (count == 8'd0))
    else $error("overflow reported with nonzero count");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (item_valid && out_valid && out_stall))
    else $error("input stalled while pipeline can move");

endmodule
